/* rtl/mtq_pkg.sv */
package mtq_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int VAL_W = 32;
    localparam int ENTRY_W = 2 * VAL_W;

    localparam logic signed [VAL_W-1:0] MIN_VAL = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic FN_PUSH = 1'b0;
    localparam logic FN_POP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL = 2'd2
    } t_status;

endpackage

/* rtl/mtq_ram.sv */
module mtq_ram
    import mtq_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/max_tracking_queue_top.sv */
// push, and pop of an empty queue: result registered in the cycle after the input word is taken
// pop from a non-empty front stack: front RAM read in S_IDLE, result taken in S_POP_WAIT, then registered
// pop with an empty front stack: S_MOVE moves all but the bottom back stack entry, one entry
//   moved per cycle through the back stack read port into the front stack write port, then returns the bottom entry
// one word in flight at a time; a new word is taken once the result register is
//   empty or in the cycle its result leaves, so pushes run at one word per cycle while m_axis_tready is high
// synchronous active-low reset empties both stacks; no memory clearing pass
module max_tracking_queue_top
    import mtq_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // value
    input  logic [0:0]  s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // popped_value, current_max
    output logic [2:0]  m_axis_tuser   // status, has_max
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_MOVE
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_fcnt, n_fcnt, r_bcnt, n_bcnt;
    logic signed [VAL_W-1:0] r_fmax, n_fmax, r_bmax, n_bmax;

    logic r_out_valid;
    logic signed [VAL_W-1:0] r_out_popped, r_out_max;
    t_status r_out_status;
    logic r_out_has;

    logic f_we, b_we;
    logic [AW-1:0] f_waddr, f_raddr, b_waddr, b_raddr;
    logic [ENTRY_W-1:0] f_wdata, f_rdata, b_wdata, b_rdata;

    logic in_acc;
    logic fin;
    logic signed [VAL_W-1:0] fin_popped, cur_max, in_value, f_rval, b_rval;
    t_status fin_status;
    logic has_any;
    logic [CW-1:0] fcnt_dec, bcnt_dec;

    mtq_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    mtq_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_value = s_axis_tdata;

    assign fcnt_dec = r_fcnt - 1'b1;
    assign bcnt_dec = r_bcnt - 1'b1;
    assign f_raddr = fcnt_dec[AW-1:0];
    assign b_raddr = bcnt_dec[AW-1:0];
    assign f_rval = f_rdata[VAL_W-1:0];
    assign b_rval = b_rdata[VAL_W-1:0];

    // entry layout: max of the entries below it, value
    assign f_waddr = r_fcnt[AW-1:0];
    assign f_wdata = {r_fmax, b_rval};
    assign b_waddr = r_bcnt[AW-1:0];
    assign b_wdata = {r_bmax, in_value};

    always_comb begin
        n_state = r_state;
        n_fcnt = r_fcnt;
        n_bcnt = r_bcnt;
        n_fmax = r_fmax;
        n_bmax = r_bmax;
        f_we = 1'b0;
        b_we = 1'b0;
        fin = 1'b0;
        fin_popped = MIN_VAL;
        fin_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] == FN_PUSH) begin
                        fin = 1'b1;
                        if (r_bcnt == CW'(STACK_DEPTH)) begin
                            fin_status = ST_FULL;
                        end else begin
                            b_we = 1'b1;
                            n_bcnt = r_bcnt + 1'b1;
                            if (r_bcnt == '0 || in_value >= r_bmax) begin
                                n_bmax = in_value;
                            end
                        end
                    end else if (r_fcnt != '0) begin
                        n_state = S_POP_WAIT;
                        n_fcnt = fcnt_dec;
                    end else if (r_bcnt != '0) begin
                        n_state = S_MOVE;
                        n_bcnt = bcnt_dec;
                    end else begin
                        fin = 1'b1;
                        fin_status = ST_EMPTY;
                    end
                end
            end
            S_POP_WAIT: begin
                fin = 1'b1;
                fin_popped = f_rval;
                n_fmax = f_rdata[ENTRY_W-1:VAL_W];
                n_state = S_IDLE;
            end
            S_MOVE: begin
                if (r_bcnt == '0) begin
                    // bottom of the back stack is the oldest word
                    fin = 1'b1;
                    fin_popped = b_rval;
                    n_state = S_IDLE;
                end else begin
                    f_we = 1'b1;
                    n_fcnt = r_fcnt + 1'b1;
                    n_bcnt = bcnt_dec;
                    if (r_fcnt == '0 || b_rval >= r_fmax) begin
                        n_fmax = b_rval;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        has_any = (n_fcnt != '0) || (n_bcnt != '0);
        if (n_fcnt != '0 && n_bcnt != '0) begin
            cur_max = (n_fmax >= n_bmax) ? n_fmax : n_bmax;
        end else if (n_fcnt != '0) begin
            cur_max = n_fmax;
        end else if (n_bcnt != '0) begin
            cur_max = n_bmax;
        end else begin
            cur_max = MIN_VAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcnt <= '0;
            r_bcnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fcnt <= n_fcnt;
            r_bcnt <= n_bcnt;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_fmax <= n_fmax;
        r_bmax <= n_bmax;
        if (fin) begin
            r_out_popped <= fin_popped;
            r_out_status <= fin_status;
            r_out_max <= cur_max;
            r_out_has <= has_any;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {r_out_max, r_out_popped};
    assign m_axis_tuser = {r_out_has, r_out_status};

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fcnt <= CW'(STACK_DEPTH)) && (r_bcnt <= CW'(STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_front_grows_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fcnt > $past(r_fcnt)) |-> $past(r_state) == S_MOVE)
        else $error("front stack grew outside a refill");

    a_empty_no_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_EMPTY) |-> !r_out_has)
        else $error("empty pop reported a maximum");

    a_none_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_has |-> r_out_max == MIN_VAL)
        else $error("empty queue maximum not minimum integer");

endmodule
